// ----- sv/smpq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// smpq_pkg
// Shared types and codes for the sorted minimum priority queue.
// ---------------------------------------------------------------------------
package smpq_pkg;

   localparam int ValueWidth = 32;

   // operation codes carried on req_tuser
   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic                         push_en;
      logic                         pop_en;
      logic signed [ValueWidth-1:0] new_value;
   } ctrl_type;

endpackage
`default_nettype wire

// ----- sv/smpq_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// smpq_cell
// One slot of the sorted chain: holds a value, compares it with the word
// being pushed and shifts toward its neighbors on push or pop.
// ---------------------------------------------------------------------------
module smpq_cell
   import smpq_pkg::*;
(
   input  wire                          clock,
   input  ctrl_type                     ctrl,
   input  wire                          occupied,
   input  wire                          take_prev,
   input  wire  signed [ValueWidth-1:0] prev_value,
   input  wire  signed [ValueWidth-1:0] next_value,
   output logic                         take,
   output logic signed [ValueWidth-1:0] value
);

   logic signed [ValueWidth-1:0] data_ff;
   logic signed [ValueWidth-1:0] data_in;

   // strict compare: an equal new value lands behind stored ones
   assign take  = !occupied || (data_ff > ctrl.new_value);
   assign value = data_ff;

   always_comb begin
      data_in = data_ff;
      if (ctrl.push_en && take) begin
         // first taking cell gets the new word, the rest shift right
         data_in = take_prev ? prev_value : ctrl.new_value;
      end else if (ctrl.pop_en) begin
         data_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule
`default_nettype wire

// ----- sv/sorted_min_priority_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sorted_min_priority_queue
// Bounded min priority queue kept as a sorted chain of compare-and-shift
// cells; push inserts in order, pop removes the head.
// ---------------------------------------------------------------------------
//  channel | ports       | contents
//  --------+-------------+-------------------------------------------------
//  request | req_t*      | tdata: value[31:0]; tuser: kind (0 push, 1 pop)
//  result  | rsp_t*      | tdata: popped_value[31:0], occupancy[36:32];
//          |             | tuser: status[1:0]
//
// One word per cycle unless the result side stalls: all cells compare against
// the pushed value in parallel and shift in the same cycle.
// The result sits in an output register from the next cycle; a new word is
// taken whenever that register is empty or is being drained.
// A stalled result holds; the request side stalls only behind it.
// Synchronous reset empties the queue; no clearing pass is needed.
// ---------------------------------------------------------------------------
module sorted_min_priority_queue
   import smpq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // [31:0] value
   input  wire  [0:0]  req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] popped_value, [36:32] occupancy
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int CntWidth = $clog2(CAPACITY + 1);

   logic [CntWidth-1:0] count_ff;
   logic [CntWidth-1:0] count_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic signed [ValueWidth-1:0] rsp_value_ff;
   logic signed [ValueWidth-1:0] rsp_value_in;
   status_type          rsp_status_ff;
   status_type          rsp_status_in;
   logic [4:0]          rsp_occ_ff;
   logic [4:0]          rsp_occ_in;

   logic                accept;
   logic                is_pop;
   logic                is_empty;
   logic                is_full;
   ctrl_type            ctrl;
   logic [CntWidth+4:0] count_wide;

   logic                         cell_take  [CAPACITY];
   logic signed [ValueWidth-1:0] cell_value [CAPACITY];

   assign accept   = req_tvalid && req_tready;
   assign is_pop   = (req_tuser[0] == KIND_POP);
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CntWidth'(CAPACITY));

   assign ctrl.push_en   = accept && !is_pop && !is_full;
   assign ctrl.pop_en    = accept && is_pop && !is_empty;
   assign ctrl.new_value = $signed(req_tdata);

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         logic                         take_prev;
         logic signed [ValueWidth-1:0] prev_value;
         logic signed [ValueWidth-1:0] next_value;
         logic                         occupied;

         assign occupied = (CntWidth'(i) < count_ff);

         if (i == 0) begin : g_head
            assign take_prev  = 1'b0;
            assign prev_value = ctrl.new_value;
         end else begin : g_body
            assign take_prev  = cell_take[i-1];
            assign prev_value = cell_value[i-1];
         end

         if (i == CAPACITY - 1) begin : g_tail
            assign next_value = cell_value[i];
         end else begin : g_inner
            assign next_value = cell_value[i+1];
         end

         smpq_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .occupied   (occupied),
            .take_prev  (take_prev),
            .prev_value (prev_value),
            .next_value (next_value),
            .take       (cell_take[i]),
            .value      (cell_value[i])
         );
      end
   endgenerate

   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (ctrl.push_en) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.pop_en) begin
         count_in = count_ff - 1'b1;
      end
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = ctrl.pop_en ? cell_value[0] : '0;
         rsp_status_in = ST_OK;
         if (is_pop && is_empty) begin
            rsp_status_in = ST_EMPTY;
         end else if (!is_pop && is_full) begin
            rsp_status_in = ST_FULL;
         end
      end
   end

   // occupancy field wraps modulo 32
   assign count_wide = {5'b0, count_in};
   assign rsp_occ_in = accept ? count_wide[4:0] : rsp_occ_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b0, rsp_occ_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntWidth'(CAPACITY))
      else $error("entry count above capacity");

   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (accept && is_pop && is_empty) |=>
         (rsp_tvalid && rsp_tuser == ST_EMPTY && count_ff == '0))
      else $error("pop on empty queue not reported");

   a_push_full: assert property (@(posedge clock) disable iff (reset)
      (accept && !is_pop && is_full) |=>
         (rsp_tuser == ST_FULL && $stable(count_ff)))
      else $error("push into full queue changed the count");

   a_push_grow: assert property (@(posedge clock) disable iff (reset)
      ctrl.push_en |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("push did not grow the queue");

endmodule
`default_nettype wire
